FILE: rtl/hglu_pkg.sv
// Shared constants and controller/datapath types for the haptic gain upsampler.
package hglu_pkg;

  localparam int SampleW      = 16;
  localparam int GainW        = 10;
  localparam int FactorW      = 9;
  localparam int ScaleProdW   = 37;  // sample x gain x factor, signed
  localparam int DefaultRatio = 16;

  localparam logic [GainW-1:0] GainUnity = 10'd256;  // 1.0 in Q2.8, bypass
  localparam logic [GainW-1:0] GainMax   = 10'd704;  // 2.75 in Q2.8

  localparam logic [FactorW-1:0] FactorA = 9'd346;  // ~1.35
  localparam logic [FactorW-1:0] FactorB = 9'd422;  // ~1.65
  localparam logic [FactorW-1:0] FactorC = 9'd397;  // ~1.55

  typedef struct packed {
    logic accept;      // capture input frame
    logic load;        // latch scaled frame, set up run
    logic interp;      // with load: run interpolates from held frame
    logic issue;       // push one phase into the output pipe
    logic load_copy;   // with issue: reload for the held-copy run
    logic run_end;     // flag the issued result
    logic buffer_end;  // flag the issued result
  } hglu_cmd_t;

  typedef struct packed {
    logic adv;   // output pipe may advance
    logic last;  // captured frame is the last of its buffer
  } hglu_status_t;

endpackage

FILE: rtl/hglu_if.sv
// Valid/ready channel interfaces: input frames, output frames, gain writes.
interface hglu_in_if import hglu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SampleW-1:0]  left_sample;
  logic signed [SampleW-1:0]  right_sample;
  logic                       last_frame;

  modport source (output valid, output left_sample, output right_sample,
                  output last_frame, input ready);
  modport sink (input valid, input left_sample, input right_sample,
                input last_frame, output ready);
endinterface

interface hglu_out_if import hglu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SampleW-1:0]  out_a;
  logic signed [SampleW-1:0]  out_b;
  logic signed [SampleW-1:0]  out_c;
  logic                       run_end;
  logic                       buffer_end;

  modport source (output valid, output out_a, output out_b, output out_c,
                  output run_end, output buffer_end, input ready);
  modport sink (input valid, input out_a, input out_b, input out_c,
                input run_end, input buffer_end, output ready);
endinterface

interface hglu_cfg_if import hglu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GainW-1:0]  gain;

  modport source (output valid, output gain, input ready);
  modport sink (input valid, input gain, output ready);
endinterface

FILE: rtl/hglu_ctrl.sv
// Sequencer: scaling steps, interpolation run and held-copy run.
module hglu_ctrl import hglu_pkg::*; #(
  parameter int RATIO = DefaultRatio
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  hglu_status_t status_i,
  output hglu_cmd_t    cmd_o
);

  localparam int PhW = $clog2(RATIO);
  localparam logic [PhW-1:0] PhLast = PhW'(RATIO - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StMul1   = 3'd1;
  localparam logic [2:0] StMul2   = 3'd2;
  localparam logic [2:0] StLoad   = 3'd3;
  localparam logic [2:0] StInterp = 3'd4;
  localparam logic [2:0] StCopy   = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [PhW-1:0] phase_q, phase_d;
  logic           held_valid_q, held_valid_d;
  hglu_cmd_t      cmd;

  always_comb begin
    cmd          = '0;
    state_d      = state_q;
    phase_d      = phase_q;
    held_valid_d = held_valid_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = StMul1;
        end
      end
      StMul1: state_d = StMul2;
      StMul2: state_d = StLoad;
      StLoad: begin
        cmd.load     = 1'b1;
        cmd.interp   = held_valid_q;
        held_valid_d = !status_i.last;
        phase_d      = '0;
        if (held_valid_q) begin
          state_d = StInterp;
        end else if (status_i.last) begin
          state_d = StCopy;
        end else begin
          state_d = StIdle;
        end
      end
      StInterp: begin
        if (status_i.adv) begin
          cmd.issue = 1'b1;
          if (phase_q == PhLast) begin
            phase_d = '0;
            if (status_i.last) begin
              cmd.load_copy = 1'b1;
              state_d       = StCopy;
            end else begin
              cmd.run_end = 1'b1;
              state_d     = StIdle;
            end
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      StCopy: begin
        if (status_i.adv) begin
          cmd.issue = 1'b1;
          if (phase_q == PhLast) begin
            cmd.run_end    = 1'b1;
            cmd.buffer_end = 1'b1;
            phase_d        = '0;
            state_d        = StIdle;
          end else begin
            phase_d = phase_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      phase_q      <= '0;
      held_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      held_valid_q <= held_valid_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign cmd_o      = cmd;

  // A phase is issued only when the output pipe can advance.
  a_issue_needs_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> status_i.adv)
    else $error("issue while output pipe stalled");

  a_copy_reload_on_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_copy |-> (cmd.issue && status_i.last))
    else $error("copy reload outside final interpolation phase");

  a_accept_starts_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> (state_q == StMul1))
    else $error("accepted frame did not enter scaling");

endmodule

FILE: rtl/hglu_dp.sv
// Datapath: gain register, channel scaling, phase accumulators, divide-by-ratio pipe.
module hglu_dp import hglu_pkg::*; #(
  parameter int RATIO = DefaultRatio
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hglu_cmd_t                  cmd_i,
  output hglu_status_t               status_o,
  input  logic                       cfg_valid_i,
  input  logic [GainW-1:0]           cfg_gain_i,
  input  logic signed [SampleW-1:0]  left_i,
  input  logic signed [SampleW-1:0]  right_i,
  input  logic                       last_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [SampleW-1:0]  out_a_o,
  output logic signed [SampleW-1:0]  out_b_o,
  output logic signed [SampleW-1:0]  out_c_o,
  output logic                       run_end_o,
  output logic                       buffer_end_o
);

  localparam int L      = $clog2(RATIO);
  localparam int MagW   = SampleW + L;       // |acc| <= RATIO * 32768
  localparam int AccW   = MagW + 1;
  localparam int ShiftW = MagW + L;
  localparam int ProdW  = 2 * MagW + 1;
  localparam int QW     = ProdW - ShiftW;
  localparam int StepW  = SampleW + 1;
  localparam int S1W    = SampleW + GainW + 1;
  localparam longint unsigned RecipVal =
    ((64'd1 << ShiftW) + 64'(RATIO) - 64'd1) / 64'(RATIO);
  localparam logic [MagW:0] Recip = (MagW + 1)'(RecipVal);
  localparam logic signed [AccW-1:0] RatioS = AccW'(RATIO);
  localparam logic [FactorW-1:0] Factor [3] = '{FactorA, FactorB, FactorC};

  function automatic logic signed [SampleW-1:0] sat16(
      input logic signed [ScaleProdW-1:0] v);
    if (v > 37'sd32767) begin
      return 16'sh7fff;
    end else if (v < -37'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[SampleW-1:0];
    end
  endfunction

  // divide by 65536 toward zero, then saturate
  function automatic logic signed [SampleW-1:0] scale_div(
      input logic signed [ScaleProdW-1:0] p);
    logic signed [ScaleProdW-1:0] b;
    b = p + $signed({21'd0, {16{p[ScaleProdW-1]}}});
    return sat16(b >>> 16);
  endfunction

  function automatic logic signed [AccW-1:0] times_ratio(
      input logic signed [SampleW-1:0] h);
    return AccW'(h) * RatioS;
  endfunction

  // gain register and frame capture
  logic [GainW-1:0]           gain_q, g_clamp, g_q;
  logic                       bypass_q, last_q;
  logic signed [SampleW-1:0]  left_q, right_q;

  logic signed [S1W-1:0]        s1_l_q, s1_r_q;
  logic signed [ScaleProdW-1:0] s2_q [3];
  logic signed [SampleW-1:0]    n_new [3];

  logic signed [SampleW-1:0]  held_q [3];
  logic signed [AccW-1:0]     acc_q [3];
  logic signed [StepW-1:0]    step_q [3];

  logic                       adv;
  logic                       p_v_q, p_run_end_q, p_buf_end_q;
  logic [ProdW-1:0]           pr_q [3];
  logic                       pneg_q [3];
  logic                       o_v_q, o_run_end_q, o_buf_end_q;
  logic signed [SampleW-1:0]  o_q [3];

  assign g_clamp = (gain_q > GainMax) ? GainMax : gain_q;
  assign adv     = !o_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainUnity;
      p_v_q  <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_gain_i;
      end
      if (adv) begin
        p_v_q <= cmd_i.issue;
        o_v_q <= p_v_q;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (bypass_q) begin
        n_new[k] = (k == 2) ? right_q : left_q;
      end else begin
        n_new[k] = scale_div(s2_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [MagW-1:0]          mag;
    logic [QW-1:0]            q;
    logic signed [QW:0]       qs;
    if (cmd_i.accept) begin
      left_q   <= left_i;
      right_q  <= right_i;
      last_q   <= last_i;
      g_q      <= g_clamp;
      bypass_q <= (g_clamp == GainUnity);
    end
    // scaling: gain product, then factor product
    s1_l_q <= left_q * $signed({1'b0, g_q});
    s1_r_q <= right_q * $signed({1'b0, g_q});
    for (int k = 0; k < 3; k++) begin
      s2_q[k] <= ((k == 2) ? s1_r_q : s1_l_q) * $signed({1'b0, Factor[k]});
    end
    // phase accumulators: acc = (RATIO - p) * h + p * n
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.load) begin
        held_q[k] <= n_new[k];
        if (cmd_i.interp) begin
          acc_q[k]  <= times_ratio(held_q[k]);
          step_q[k] <= StepW'(n_new[k]) - StepW'(held_q[k]);
        end else begin
          acc_q[k]  <= times_ratio(n_new[k]);
          step_q[k] <= '0;
        end
      end else if (cmd_i.issue) begin
        if (cmd_i.load_copy) begin
          acc_q[k]  <= times_ratio(held_q[k]);
          step_q[k] <= '0;
        end else begin
          acc_q[k] <= acc_q[k] + AccW'(step_q[k]);
        end
      end
    end
    // divide by RATIO toward zero: reciprocal multiply on the magnitude
    if (adv) begin
      p_run_end_q <= cmd_i.run_end;
      p_buf_end_q <= cmd_i.buffer_end;
      o_run_end_q <= p_run_end_q;
      o_buf_end_q <= p_buf_end_q;
      for (int k = 0; k < 3; k++) begin
        mag       = acc_q[k][AccW-1] ? MagW'(-acc_q[k]) : MagW'(acc_q[k]);
        pr_q[k]   <= ProdW'(mag) * ProdW'(Recip);
        pneg_q[k] <= acc_q[k][AccW-1];
        q         = pr_q[k][ProdW-1:ShiftW];
        qs        = $signed({1'b0, q});
        o_q[k]    <= sat16(ScaleProdW'(pneg_q[k] ? -qs : qs));
      end
    end
  end

  assign status_o.adv  = adv;
  assign status_o.last = last_q;

  assign out_valid_o  = o_v_q;
  assign out_a_o      = o_q[0];
  assign out_b_o      = o_q[1];
  assign out_c_o      = o_q[2];
  assign run_end_o    = o_run_end_q;
  assign buffer_end_o = o_buf_end_q;

endmodule

FILE: rtl/haptic_gain_linear_upsampler_core.sv
// Top level: haptic gain scaler with linear-interpolating upsampler.
// A frame that starts a run passes the scaling steps and the load, then the product and
// output registers of the divide pipe. Each frame takes the scaling steps, the load,
// and RATIO issues if a frame is held, RATIO more on a last frame; one transfer per run.
// The issue loop emits one output frame per cycle; output stalls hold the whole pipe.
// Reset: gain returns to 256 (bypass), no frame is held, all pipe stages empty.
module haptic_gain_linear_upsampler_core import hglu_pkg::*; #(
  parameter int RATIO = DefaultRatio
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hglu_in_if.sink    in_i,
  hglu_out_if.source out_o,
  hglu_cfg_if.sink   cfg_i
);

  hglu_cmd_t    cmd;
  hglu_status_t status;
  logic         in_ready;

  // Controller: scaling steps, then one issue per cycle over RATIO phases unless stalled.
  hglu_ctrl #(
    .RATIO (RATIO)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: gain register, two multiply stages, accumulators, divide pipe.
  hglu_dp #(
    .RATIO (RATIO)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_gain_i   (cfg_i.gain),
    .left_i       (in_i.left_sample),
    .right_i      (in_i.right_sample),
    .last_i       (in_i.last_frame),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_a_o      (out_o.out_a),
    .out_b_o      (out_o.out_b),
    .out_c_o      (out_o.out_c),
    .run_end_o    (out_o.run_end),
    .buffer_end_o (out_o.buffer_end)
  );

  assign in_i.ready  = in_ready;
  // gain writes are registered; user must keep gain only written while idle; not enforced
  assign cfg_i.ready = 1'b1;

  // buffer end is always the final result of its transfer
  a_buf_end_is_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.buffer_end) |-> out_o.run_end)
    else $error("buffer_end without run_end");

  // no new frame transfer while a frame is being worked on
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready right after a transfer");

  // the controller never accepts and issues in the same cycle
  a_accept_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |-> !cmd.issue)
    else $error("accept during issue run");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the haptic gain linear upsampler core.
`timescale 1ns / 100ps
module tb import hglu_pkg::*; ();

  localparam int Ratio          = DefaultRatio;
  localparam int ResetCycles    = 8;
  localparam int SettleCycles   = 16;      // > output latency plus the frame prep
  localparam int LongHoldCycles = 400;     // output blocked long enough to back up the input
  localparam int CycleLimit     = 600000;
  localparam int MaxReports     = 10;
  localparam int PhaseItems     = 56;
  localparam int NumPhases      = 8;
  localparam int DirRows        = 22;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef enum logic {ROW_FRAME, ROW_GAIN} row_kind_e;
  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_BLOCKED} rx_mode_e;

  // One stimulus step: either a frame or a gain write. When typed is set the scaled
  // frame is known by inspection and want_* replaces the computed one.
  typedef struct {
    row_kind_e        kind;
    sample_t          left;
    sample_t          right;
    logic             last;
    logic [GainW-1:0] gain;
    logic             typed;
    sample_t          want_a;
    sample_t          want_b;
    sample_t          want_c;
  } stim_row_t;

  typedef struct {
    sample_t a;
    sample_t b;
    sample_t c;
    logic    run_end;
    logic    buffer_end;
  } out_frame_t;

  logic clk;
  logic rst_n = 1'b0;

  hglu_in_if  in_bus ();
  hglu_out_if out_bus ();
  hglu_cfg_if cfg_bus ();

  haptic_gain_linear_upsampler_core #(
    .RATIO (Ratio)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Predictor state: the gain register and the held scaled frame
  logic [GainW-1:0] gain_now = GainUnity;
  bit               held_ok  = 1'b0;
  sample_t          held_a   = '0;
  sample_t          held_b   = '0;
  sample_t          held_c   = '0;

  out_frame_t pending_q[$];   // output frames still owed by the block, oldest first

  int unsigned cycle_cnt    = 0;
  int unsigned mismatches   = 0;
  int unsigned frames_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned gain_writes  = 0;
  bit          in_live      = 1'b0;   // input valid currently driven high
  bit          rx_hold_req  = 1'b0;   // ask the receiver for one long hold-off

  // Directed table: bypass after reset, rail values, truncation toward zero on
  // negative products, clamp above 2.75, gain change mid-buffer, buffers of one frame.
  stim_row_t dir_rows [DirRows] = '{
    '{ROW_FRAME, 100, -200, 1'b1, '0, 1'b1, 100, 100, -200},         // bypass copies
    '{ROW_FRAME, 32767, -32768, 1'b0, '0, 1'b0, 0, 0, 0},            // opens a buffer
    '{ROW_FRAME, -32768, 32767, 1'b1, '0, 1'b1, -32768, -32768, 32767},
    '{ROW_FRAME, 0, 0, 1'b1, '0, 1'b1, 0, 0, 0},
    '{ROW_GAIN, 0, 0, 1'b0, 10'd0, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 1234, -5678, 1'b0, '0, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 32767, -32768, 1'b1, '0, 1'b1, 0, 0, 0},            // zero gain
    '{ROW_GAIN, 0, 0, 1'b0, GainMax, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 32767, -32768, 1'b1, '0, 1'b1, 32767, 32767, -32768}, // saturation
    '{ROW_FRAME, -1, 1, 1'b0, '0, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 100, -100, 1'b1, '0, 1'b1, 371, 453, -426},
    '{ROW_GAIN, 0, 0, 1'b0, 10'h3ff, 1'b0, 0, 0, 0},                 // clamps to 704
    '{ROW_FRAME, 1, -1, 1'b1, '0, 1'b1, 3, 4, -4},
    '{ROW_GAIN, 0, 0, 1'b0, 10'd257, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 21845, -21846, 1'b0, '0, 1'b0, 0, 0, 0},
    '{ROW_GAIN, 0, 0, 1'b0, 10'd255, 1'b0, 0, 0, 0},                 // mid-buffer change
    '{ROW_FRAME, -21846, 21845, 1'b0, '0, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 32767, 32767, 1'b1, '0, 1'b0, 0, 0, 0},
    '{ROW_GAIN, 0, 0, 1'b0, GainUnity, 1'b0, 0, 0, 0},
    '{ROW_FRAME, 7, 9, 1'b0, '0, 1'b0, 0, 0, 0},
    '{ROW_FRAME, -7, -9, 1'b0, '0, 1'b0, 0, 0, 0},                   // negative steps
    '{ROW_FRAME, 5, -3, 1'b1, '0, 1'b0, 0, 0, 0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("timeout after %0d cycles, %0d output frames still owed",
             cycle_cnt, pending_q.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic sample_t clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // Q2.8 gain times Q8 channel factor, truncated toward zero; unity bypasses all
  function automatic sample_t apply_gain(sample_t s, logic [GainW-1:0] g,
                                         logic [FactorW-1:0] f);
    longint prod;
    if (g == GainUnity) return s;
    prod = longint'(s) * longint'(g) * longint'(f);
    return clip16(prod / 65536);
  endfunction

  function automatic sample_t blend(sample_t h, sample_t n, int ph);
    int mixed;
    mixed = ((Ratio - ph) * int'(h) + ph * int'(n)) / Ratio;
    return clip16(mixed);
  endfunction

  // Called at the transfer of a frame: queues the interpolated run from the held
  // frame, then the held copies if this frame closes its buffer.
  task automatic predict_frame(input stim_row_t row);
    logic [GainW-1:0] g;
    sample_t          na, nb, nc;
    int               total, k, ph;
    out_frame_t       o;
    g  = (gain_now > GainMax) ? GainMax : gain_now;
    na = apply_gain(row.left, g, FactorA);
    nb = apply_gain(row.left, g, FactorB);
    nc = apply_gain(row.right, g, FactorC);
    if (row.typed) begin
      na = row.want_a;
      nb = row.want_b;
      nc = row.want_c;
    end
    total = (held_ok ? Ratio : 0) + (row.last ? Ratio : 0);
    k = 0;
    if (held_ok) begin
      for (ph = 0; ph < Ratio; ph++) begin
        o.a = blend(held_a, na, ph);
        o.b = blend(held_b, nb, ph);
        o.c = blend(held_c, nc, ph);
        o.run_end    = (k == total - 1);
        o.buffer_end = o.run_end && row.last;
        pending_q.push_back(o);
        k++;
      end
    end
    if (row.last) begin
      for (ph = 0; ph < Ratio; ph++) begin
        o.a = na;
        o.b = nb;
        o.c = nc;
        o.run_end    = (k == total - 1);
        o.buffer_end = o.run_end;
        pending_q.push_back(o);
        k++;
      end
    end
    held_a  = na;
    held_b  = nb;
    held_c  = nc;
    held_ok = !row.last;
  endtask

  // ---------------------------------------------------------------------------
  // Random shaping
  // ---------------------------------------------------------------------------

  // Rails and the values around zero show up often; the rest is full range.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return ($urandom_range(0, 1) != 0) ? 16'sh0000 : 16'shffff;
      3: return sample_t'(int'($urandom_range(0, 600)) - 300);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned buffer_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 1;
    if (r < 80) return $urandom_range(2, 4);
    return $urandom_range(5, 12);
  endfunction

  // ---------------------------------------------------------------------------
  // Input and gain-write drivers
  // ---------------------------------------------------------------------------

  // valid stays high across back-to-back frames; it only drops for a gap.
  task automatic send_frame(input stim_row_t row, input int unsigned gap);
    if (gap != 0) begin
      if (in_live) begin
        in_bus.valid <= 1'b0;
        in_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.left_sample  <= row.left;
    in_bus.right_sample <= row.right;
    in_bus.last_frame   <= row.last;
    in_live = 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    predict_frame(row);
    frames_sent++;
  endtask

  // Stop offering frames, wait for every owed output, then let the pipe go quiet.
  task automatic settle_block();
    if (in_live) begin
      in_bus.valid <= 1'b0;
      in_live = 1'b0;
    end
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_gain(input logic [GainW-1:0] g);
    settle_block();
    cfg_bus.valid <= 1'b1;
    cfg_bus.gain  <= g;
    do @(posedge clk); while (!cfg_bus.ready);
    gain_now = g;
    gain_writes++;
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: check each transfer, then pick the next ready
  // ---------------------------------------------------------------------------

  initial begin
    rx_mode_e    mode;
    int unsigned seg_left;
    int unsigned hold_left;
    out_frame_t  want;
    mode      = RX_OPEN;
    seg_left  = 0;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("cycle %0d: output frame with nothing owed: a=%0d b=%0d c=%0d",
                     cycle_cnt, out_bus.out_a, out_bus.out_b, out_bus.out_c);
        end else begin
          want = pending_q.pop_front();
          if (out_bus.out_a !== want.a || out_bus.out_b !== want.b ||
              out_bus.out_c !== want.c || out_bus.run_end !== want.run_end ||
              out_bus.buffer_end !== want.buffer_end) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("cycle %0d: exp a=%0d b=%0d c=%0d run_end=%0b buffer_end=%0b",
                       cycle_cnt, want.a, want.b, want.c, want.run_end, want.buffer_end);
              $display("           got a=%0d b=%0d c=%0d run_end=%0b buffer_end=%0b",
                       out_bus.out_a, out_bus.out_b, out_bus.out_c,
                       out_bus.run_end, out_bus.buffer_end);
            end
          end
        end
      end

      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = LongHoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        // Segments: wide open, choppy, or blocked for a while
        if (seg_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
              mode = RX_OPEN;
              seg_left = $urandom_range(10, 60);
            end
            9: begin
              mode = RX_BLOCKED;
              seg_left = $urandom_range(5, 40);
            end
            default: begin
              mode = RX_CHOPPY;
              seg_left = $urandom_range(10, 60);
            end
          endcase
        end
        seg_left--;
        case (mode)
          RX_OPEN:    out_bus.ready <= 1'b1;
          RX_CHOPPY:  out_bus.ready <= ($urandom_range(0, 99) < 70);
          default:    out_bus.ready <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    stim_row_t        row;
    int unsigned      frames_left;
    bit               no_gap;
    logic [GainW-1:0] phase_gain;
    in_bus.valid        <= 1'b0;
    in_bus.left_sample  <= '0;
    in_bus.right_sample <= '0;
    in_bus.last_frame   <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.gain        <= GainUnity;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].kind == ROW_GAIN)
        write_gain(dir_rows[i].gain);
      else
        send_frame(dir_rows[i], gap_len());
    end

    // Random buffers of well-formed frames, one gain setting per phase. A phase
    // may end mid-buffer, so the next gain applies to a buffer already open.
    frames_left = 0;
    row.kind    = ROW_FRAME;
    row.gain    = '0;
    row.typed   = 1'b0;
    row.want_a  = '0;
    row.want_b  = '0;
    row.want_c  = '0;
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: phase_gain = GainUnity;
        1: phase_gain = 10'd0;
        2: phase_gain = GainMax;
        3: phase_gain = 10'h3ff;
        4: phase_gain = 10'd384;
        5: phase_gain = 10'd1;
        6: phase_gain = GainW'($urandom_range(0, 1023));
        default: phase_gain = GainW'($urandom_range(0, 703));
      endcase
      write_gain(phase_gain);
      no_gap = (p == 1 || p == 5);
      // Output held off while frames keep coming: the pipe fills and input stalls
      if (p == 2) rx_hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        // Sender pause: let everything owed drain before going on
        if (p == 4 && i == PhaseItems / 2) settle_block();
        if (frames_left == 0) frames_left = buffer_len();
        row.left  = pick_sample();
        row.right = pick_sample();
        row.last  = (frames_left == 1);
        frames_left--;
        send_frame(row, no_gap ? 0 : gap_len());
      end
    end

    settle_block();

    $display("Covered %0d frames over %0d gain writes (bypass, zero, 2.75, clamp, random).",
             frames_sent, gain_writes);
    $display("Checked %0d output frames, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hglu_pkg.sv
rtl/hglu_if.sv
rtl/hglu_ctrl.sv
rtl/hglu_dp.sv
rtl/haptic_gain_linear_upsampler_core.sv
tb/sv/tb.sv
